@@ rtl/tsb_pkg.sv @@
// ----------------------------------------------------------------------------
// tsb_pkg: texture sampler shared definitions
// Widths, codes and the structs that pass between the sampler's units.
// ----------------------------------------------------------------------------
package tsb_pkg;

  // Texture store and coordinate format
  localparam int TEXEL_DEPTH    = 65536;
  localparam int FRAC_BITS      = 8;
  localparam int COORD_INT_BITS = 12;
  localparam int ADDR_W         = $clog2(TEXEL_DEPTH);

  // Fixed field widths of the stream payload
  localparam int CMD_W     = 1;
  localparam int ADDR_IN_W = 16;
  localparam int TEXEL_W   = 32;
  localparam int COORD_W   = 20;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = TEXEL_W / CHAN_W;

  // Input tdata layout, first field lowest
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_ARGB_LSB  = IN_ADDR_LSB + ADDR_IN_W;
  localparam int IN_U_LSB     = IN_ARGB_LSB + TEXEL_W;
  localparam int IN_V_LSB     = IN_U_LSB + COORD_W;
  localparam int IN_FIELDS_W  = IN_V_LSB + COORD_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = NUM_CHAN * CHAN_W;

  // Texture dimensions: 1..256 texels, total up to 65536 texels
  localparam int DIM_W    = 9;
  localparam int DIM_MAX  = 256;
  localparam int REM_W    = 16;
  localparam int TOTAL_W  = REM_W + 1;
  localparam int BASE_W   = COORD_INT_BITS + DIM_W;

  // Weights: truncated fraction products scaled to WEIGHT_ONE
  localparam int WEIGHT_ONE = 256;
  localparam int WT_W       = 9;
  localparam int WT_SHIFT   = 2 * FRAC_BITS - 8;
  localparam int ACC_W      = CHAN_W + WT_W + 2;
  localparam int NBR_N      = 4;
  localparam int STEP_W     = $clog2(NBR_N);

  // Side field carries the write address or the packed fractions
  localparam int AUX_W = (ADDR_IN_W > 2 * FRAC_BITS) ? ADDR_IN_W : 2 * FRAC_BITS;

  // Result queue
  localparam int OUT_DEPTH = 2;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEX_WIDTH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TEX_HEIGHT  = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic               bilinear;
    logic [DIM_W-1:0]   w;
    logic [TOTAL_W-1:0] total;
  } cfg_t;

  // One item in flight: command, address or fractions, texel, wrapped index
  typedef struct packed {
    logic               cmd;
    logic [AUX_W-1:0]   aux;
    logic [TEXEL_W-1:0] data;
    logic [REM_W-1:0]   rem;
  } item_t;

  // Tag riding along with each texture read
  typedef struct packed {
    logic            vld;
    logic            first;
    logic            last;
    logic [WT_W-1:0] wt;
  } rd_tag_t;

endpackage

@@ rtl/texture_sampler_bilinear.sv @@
// ----------------------------------------------------------------------------
// texture_sampler_bilinear: nearest / bilinear texture sampler
// Throughput: one beat per cycle for texel writes and nearest samples while
//   results can be queued; a bilinear sample reads its four neighbors in turn
//   from the single-port texel store, one read at a time.
// Reset: rst_n (synchronous) clears control state and sets filter_mode=1,
//   tex_width=256, tex_height=256; the texel store is not cleared.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, low to high: texel_address[15:0], texel_argb[47:16],
  // coord_u[67:48], coord_v[87:68]
  input  logic [tsb_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,   // command
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, low to high: out_alpha[7:0], out_red[15:8], out_green[23:16],
  // out_blue[31:24]
  output logic [tsb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tsb_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tsb_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tsb_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                          filter_mode_r;
  logic [tsb_pkg::DIM_W-1:0]     tex_width_r, tex_height_r;
  logic [tsb_pkg::DIM_W-1:0]     w_r;
  logic [tsb_pkg::TOTAL_W-1:0]   total_r;
  logic [tsb_pkg::DIM_W-1:0]     w_c, h_c;
  logic [tsb_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  tsb_pkg::cfg_t                 cfg;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[tsb_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= tsb_pkg::FILTER_BILINEAR;
      tex_width_r   <= tsb_pkg::DIM_W'(tsb_pkg::DIM_MAX);
      tex_height_r  <= tsb_pkg::DIM_W'(tsb_pkg::DIM_MAX);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tsb_pkg::REG_FILTER_MODE: filter_mode_r <= cfg_pwdata[0];
        tsb_pkg::REG_TEX_WIDTH:   tex_width_r   <= cfg_pwdata[tsb_pkg::DIM_W-1:0];
        tsb_pkg::REG_TEX_HEIGHT:  tex_height_r  <= cfg_pwdata[tsb_pkg::DIM_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tsb_pkg::REG_FILTER_MODE: cfg_prdata = tsb_pkg::CFG_DATA_W'(filter_mode_r);
      tsb_pkg::REG_TEX_WIDTH:   cfg_prdata = tsb_pkg::CFG_DATA_W'(tex_width_r);
      tsb_pkg::REG_TEX_HEIGHT:  cfg_prdata = tsb_pkg::CFG_DATA_W'(tex_height_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // Clamp the dimensions to 1..256: zero means one, anything larger saturates
  always_comb begin
    if (tex_width_r == '0) begin
      w_c = tsb_pkg::DIM_W'(1);
    end else if (tex_width_r > tsb_pkg::DIM_W'(tsb_pkg::DIM_MAX)) begin
      w_c = tsb_pkg::DIM_W'(tsb_pkg::DIM_MAX);
    end else begin
      w_c = tex_width_r;
    end
    if (tex_height_r == '0) begin
      h_c = tsb_pkg::DIM_W'(1);
    end else if (tex_height_r > tsb_pkg::DIM_W'(tsb_pkg::DIM_MAX)) begin
      h_c = tsb_pkg::DIM_W'(tsb_pkg::DIM_MAX);
    end else begin
      h_c = tex_height_r;
    end
  end

  // Hold the clamped width and texel count in registers; the user changes config
  // only while the datapath is idle (not enforced), so the lag is harmless
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= tsb_pkg::DIM_W'(tsb_pkg::DIM_MAX);
      total_r <= tsb_pkg::TOTAL_W'(tsb_pkg::DIM_MAX * tsb_pkg::DIM_MAX);
    end else begin
      w_r     <= w_c;
      total_r <= tsb_pkg::TOTAL_W'(w_c) * tsb_pkg::TOTAL_W'(h_c);
    end
  end

  assign cfg = '{bilinear: filter_mode_r, w: w_r, total: total_r};

  // --------------------------------------------------------------------------
  // Datapath: index pipeline -> memory sequencer -> blend and result queue.
  // All items, writes included, go through the same in-order path so a write
  // is seen by exactly the samples that follow it.
  // --------------------------------------------------------------------------
  logic             adv;
  logic             pipe_vld;
  tsb_pkg::item_t   pipe_item;
  tsb_pkg::rd_tag_t rd_tag;
  logic [tsb_pkg::TEXEL_W-1:0] rd_data;
  logic [tsb_pkg::TEXEL_W-1:0] out_argb;
  logic             pop;

  // The whole index pipeline advances when the sequencer takes its next item
  assign in_tready = adv;

  tsb_addr_pipe u_addr_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_tvalid),
    .in_cmd   (in_tuser),
    .in_addr  (in_tdata[tsb_pkg::IN_ADDR_LSB +: tsb_pkg::ADDR_IN_W]),
    .in_argb  (in_tdata[tsb_pkg::IN_ARGB_LSB +: tsb_pkg::TEXEL_W]),
    .in_u     (in_tdata[tsb_pkg::IN_U_LSB +: tsb_pkg::COORD_W]),
    .in_v     (in_tdata[tsb_pkg::IN_V_LSB +: tsb_pkg::COORD_W]),
    .cfg      (cfg),
    .out_vld  (pipe_vld),
    .out_item (pipe_item)
  );

  // One memory access per cycle; the final read of a sample waits for a
  // free result slot, which keeps the result queue from overflowing
  tsb_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_vld  (pipe_vld),
    .in_item (pipe_item),
    .pop     (pop),
    .take    (adv),
    .tag     (rd_tag),
    .rdata   (rd_data)
  );

  tsb_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (rd_tag),
    .rdata      (rd_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_argb   (out_argb),
    .pop        (pop)
  );

  // Repack ARGB so alpha lands in the lowest byte
  assign out_tdata = {out_argb[7:0], out_argb[15:8], out_argb[23:16], out_argb[31:24]};

endmodule

@@ rtl/tsb_addr_pipe.sv @@
// ----------------------------------------------------------------------------
// tsb_addr_pipe: sample index pipeline
// Forms v*width+u and reduces it modulo width*height, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tsb_addr_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic                                in_cmd,
  input  logic [tsb_pkg::ADDR_IN_W-1:0]       in_addr,
  input  logic [tsb_pkg::TEXEL_W-1:0]         in_argb,
  input  logic [tsb_pkg::COORD_W-1:0]         in_u,
  input  logic [tsb_pkg::COORD_W-1:0]         in_v,
  input  tsb_pkg::cfg_t                       cfg,
  output logic                                out_vld,
  output tsb_pkg::item_t                      out_item
);

  localparam int NST = tsb_pkg::BASE_W + 1;

  logic                              vld_r [NST];
  tsb_pkg::item_t                    stg_r [NST];
  logic [tsb_pkg::BASE_W-1:0]        dvd_r [NST];

  logic [tsb_pkg::COORD_INT_BITS-1:0] ui, vi;
  logic [tsb_pkg::FRAC_BITS-1:0]      fu, fv;
  logic [tsb_pkg::AUX_W-1:0]          aux_in;
  logic [tsb_pkg::BASE_W-1:0]         base;

  always_comb begin
    ui     = tsb_pkg::COORD_INT_BITS'(in_u >> tsb_pkg::FRAC_BITS);
    vi     = tsb_pkg::COORD_INT_BITS'(in_v >> tsb_pkg::FRAC_BITS);
    fu     = in_u[tsb_pkg::FRAC_BITS-1:0];
    fv     = in_v[tsb_pkg::FRAC_BITS-1:0];
    aux_in = (in_cmd == tsb_pkg::CMD_WRITE) ? tsb_pkg::AUX_W'(in_addr)
                                            : tsb_pkg::AUX_W'({fv, fu});
    base   = tsb_pkg::BASE_W'(vi) * tsb_pkg::BASE_W'(cfg.w) + tsb_pkg::BASE_W'(ui);
  end

  // Entry stage: linear index before the wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
    if (adv) begin
      stg_r[0] <= '{cmd: in_cmd, aux: aux_in, data: in_argb, rem: '0};
      dvd_r[0] <= base;
    end
  end

  // Restoring remainder: shift in one dividend bit, subtract when it fits
  for (genvar j = 0; j < tsb_pkg::BASE_W; j++) begin : g_step
    logic [tsb_pkg::TOTAL_W-1:0] t, d;

    always_comb begin
      t = {stg_r[j].rem, dvd_r[j][tsb_pkg::BASE_W-1]};
      d = t - cfg.total;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (adv) begin
        vld_r[j+1] <= vld_r[j];
      end
      if (adv) begin
        stg_r[j+1] <= '{cmd:  stg_r[j].cmd,
                        aux:  stg_r[j].aux,
                        data: stg_r[j].data,
                        rem:  (t >= cfg.total) ? d[tsb_pkg::REM_W-1:0]
                                               : t[tsb_pkg::REM_W-1:0]};
        dvd_r[j+1] <= dvd_r[j] << 1;
      end
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_item = stg_r[NST-1];

endmodule

@@ rtl/tsb_seq.sv @@
// ----------------------------------------------------------------------------
// tsb_seq: texture memory sequencer
// Owns the texel store; issues one write or up to four neighbor reads per item.
// ----------------------------------------------------------------------------
module tsb_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsb_pkg::cfg_t                 cfg,
  input  logic                          in_vld,
  input  tsb_pkg::item_t                in_item,
  input  logic                          pop,
  output logic                          take,
  output tsb_pkg::rd_tag_t              tag,
  output logic [tsb_pkg::TEXEL_W-1:0]   rdata
);

  localparam logic [tsb_pkg::FRAC_BITS:0] ONE = (tsb_pkg::FRAC_BITS+1)'(1) << tsb_pkg::FRAC_BITS;

  logic [tsb_pkg::TEXEL_W-1:0] mem [tsb_pkg::TEXEL_DEPTH];

  logic                           vld_r;
  tsb_pkg::item_t                 item_r;
  logic [tsb_pkg::REM_W-1:0]      r2_r;
  logic [tsb_pkg::STEP_W-1:0]     step_r;
  logic [tsb_pkg::CNT_W-1:0]      resv_r;
  logic                           tag_vld_r, tag_first_r, tag_last_r;
  logic [tsb_pkg::WT_W-1:0]       tag_wt_r;
  logic [tsb_pkg::TEXEL_W-1:0]    rdata_r;

  logic                           issue_ok, is_smp, last_step, rd_en, wr_en, done;
  logic [tsb_pkg::REM_W-1:0]      src, rd_addr, r2_nxt;
  logic [tsb_pkg::TOTAL_W-1:0]    sum, sum2;
  logic [tsb_pkg::FRAC_BITS-1:0]  fu, fv;
  logic [tsb_pkg::FRAC_BITS:0]    fa, fb;
  logic [2*tsb_pkg::FRAC_BITS+1:0] wprod;
  logic [tsb_pkg::WT_W-1:0]       wt;

  always_comb begin
    // a result slot must be free before the closing read goes out
    issue_ok  = (resv_r < tsb_pkg::CNT_W'(tsb_pkg::OUT_DEPTH)) || pop;
    is_smp    = item_r.cmd == tsb_pkg::CMD_SAMPLE;
    last_step = (cfg.bilinear == tsb_pkg::FILTER_NEAREST) ||
                (step_r == tsb_pkg::STEP_W'(tsb_pkg::NBR_N - 1));
    wr_en     = vld_r && !is_smp;
    rd_en     = vld_r && is_smp && (!last_step || issue_ok);
    done      = wr_en || (rd_en && last_step);
    take      = !vld_r || done;

    // neighbors: base, base+1, base+width, base+width+1, each wrapped
    src     = step_r[1] ? r2_r : item_r.rem;
    sum     = {1'b0, src} + tsb_pkg::TOTAL_W'(step_r[0]);
    rd_addr = (sum >= cfg.total) ? tsb_pkg::REM_W'(sum - cfg.total) : sum[tsb_pkg::REM_W-1:0];

    sum2    = {1'b0, in_item.rem} + tsb_pkg::TOTAL_W'(cfg.w);
    r2_nxt  = (sum2 >= cfg.total) ? tsb_pkg::REM_W'(sum2 - cfg.total)
                                  : sum2[tsb_pkg::REM_W-1:0];

    fu    = item_r.aux[tsb_pkg::FRAC_BITS-1:0];
    fv    = item_r.aux[2*tsb_pkg::FRAC_BITS-1:tsb_pkg::FRAC_BITS];
    fa    = step_r[0] ? {1'b0, fu} : ONE - {1'b0, fu};
    fb    = step_r[1] ? {1'b0, fv} : ONE - {1'b0, fv};
    wprod = (2*tsb_pkg::FRAC_BITS+2)'(fa) * (2*tsb_pkg::FRAC_BITS+2)'(fb);
    wt    = (cfg.bilinear == tsb_pkg::FILTER_BILINEAR) ? wprod[tsb_pkg::WT_SHIFT +: tsb_pkg::WT_W]
                                                       : tsb_pkg::WT_W'(tsb_pkg::WEIGHT_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      step_r    <= '0;
      resv_r    <= '0;
      tag_vld_r <= 1'b0;
    end else begin
      if (take) begin
        vld_r  <= in_vld;
        step_r <= '0;
      end else if (rd_en) begin
        step_r <= step_r + tsb_pkg::STEP_W'(1);
      end
      resv_r    <= resv_r + tsb_pkg::CNT_W'(rd_en && last_step) - tsb_pkg::CNT_W'(pop);
      tag_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
      r2_r   <= r2_nxt;
    end
    tag_first_r <= step_r == '0;
    tag_last_r  <= last_step;
    tag_wt_r    <= wt;
  end

  // Single-port texel store, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tsb_pkg::ADDR_W'(item_r.aux)] <= item_r.data;
    end
    if (rd_en) begin
      rdata_r <= mem[tsb_pkg::ADDR_W'(rd_addr)];
    end
  end

  assign tag   = '{vld: tag_vld_r, first: tag_first_r, last: tag_last_r, wt: tag_wt_r};
  assign rdata = rdata_r;

endmodule

@@ rtl/tsb_blend.sv @@
// ----------------------------------------------------------------------------
// tsb_blend: weighted channel accumulate and result queue
// Adds one weighted texel per beat of read data; queues finished samples.
// ----------------------------------------------------------------------------
module tsb_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsb_pkg::rd_tag_t              tag,
  input  logic [tsb_pkg::TEXEL_W-1:0]   rdata,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [tsb_pkg::TEXEL_W-1:0]   out_argb,
  output logic                          pop
);

  logic [tsb_pkg::ACC_W-1:0]   acc_r [tsb_pkg::NUM_CHAN];
  logic [tsb_pkg::ACC_W-1:0]   sum   [tsb_pkg::NUM_CHAN];
  logic [tsb_pkg::TEXEL_W-1:0] res;
  logic [tsb_pkg::TEXEL_W-1:0] fifo_r [tsb_pkg::OUT_DEPTH];
  logic [tsb_pkg::PTR_W-1:0]   wp_r, rp_r;
  logic [tsb_pkg::CNT_W-1:0]   cnt_r;
  logic                        push;

  always_comb begin
    for (int b = 0; b < tsb_pkg::NUM_CHAN; b++) begin
      sum[b] = (tag.first ? '0 : acc_r[b]) +
               tsb_pkg::ACC_W'(rdata[b*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W]) *
               tsb_pkg::ACC_W'(tag.wt);
      res[b*tsb_pkg::CHAN_W +: tsb_pkg::CHAN_W] = sum[b][8 +: tsb_pkg::CHAN_W];
    end
    push       = tag.vld && tag.last;
    out_tvalid = cnt_r != '0;
    pop        = out_tvalid && out_tready;
    out_argb   = fifo_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (tag.vld) begin
      for (int b = 0; b < tsb_pkg::NUM_CHAN; b++) begin
        acc_r[b] <= sum[b];
      end
    end
    if (push) begin
      fifo_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == tsb_pkg::PTR_W'(tsb_pkg::OUT_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == tsb_pkg::PTR_W'(tsb_pkg::OUT_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + tsb_pkg::CNT_W'(push) - tsb_pkg::CNT_W'(pop);
    end
  end

endmodule

@@ rtl/tsb_checker.sv @@
// ----------------------------------------------------------------------------
// tsb_checker: port-level checks for the texture sampler
// Tracks outstanding samples and checks result handshake and reset rules.
// ----------------------------------------------------------------------------
module tsb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tsb_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [5:0] pend_r;
  logic [5:0] pend_nxt;
  logic       smp_in, res_out;

  assign smp_in   = in_tvalid && in_tready && (in_tuser == tsb_pkg::CMD_SAMPLE);
  assign res_out  = out_tvalid && out_tready;
  assign pend_nxt = pend_r + 6'(smp_in) - 6'(res_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 6'd0)
    else $error("result beat without an outstanding sample");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind texture_sampler_bilinear tsb_checker u_tsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: texture sampler testbench
// Runs directed and random write and sample beats under a series of filter
// and size settings. Before a sample goes out, every texel it can reach has
// been written at least once. A built-in predictor mirrors the texel store and
// the registers and checks every sampled ARGB beat channel by channel, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tsb_pkg::*;

  // Register slot just past the defined ones; writes to it must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Quiet time before a register write: longest pipeline latency plus margin
  localparam int SETTLE_CYCLES = 40;
  // Long receiver hold-off that backs the pipeline up into the input
  localparam int HOLD_CYCLES   = 400;
  // Run limit, well above the slowest legal run
  localparam longint RUN_LIMIT = 64'd5_000_000;

  // --------------------------------------------------------------------------
  // Predictor and result store
  // --------------------------------------------------------------------------
  class sample_checker;
    logic [TEXEL_W-1:0]     texels [TEXEL_DEPTH];
    logic                   bilinear;
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    logic [OUT_TDATA_W-1:0] pending_samples [$];
    int                     mismatches;
    string                  lane_name [NUM_CHAN] = '{"alpha", "red", "green", "blue"};

    function new();
      bilinear   = FILTER_BILINEAR;
      width_reg  = DIM_W'(DIM_MAX);
      height_reg = DIM_W'(DIM_MAX);
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // Zero counts as one, anything past the maximum saturates
    function int unsigned dim_of(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM_MAX) return DIM_MAX;
      return 32'(d);
    endfunction

    function logic [CFG_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_FILTER_MODE: return CFG_DATA_W'(bilinear);
        REG_TEX_WIDTH:   return CFG_DATA_W'(width_reg);
        REG_TEX_HEIGHT:  return CFG_DATA_W'(height_reg);
        default:         return '0;
      endcase
    endfunction

    function void take_config(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr[CFG_ADDR_W-1:2])
        REG_FILTER_MODE: bilinear   = data[0];
        REG_TEX_WIDTH:   width_reg  = data[DIM_W-1:0];
        REG_TEX_HEIGHT:  height_reg = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Store a texel, or work out the ARGB result of a sample
    function void take_input(logic cmd, logic [IN_TDATA_W-1:0] beat);
      logic [COORD_W-1:0]     u;
      logic [COORD_W-1:0]     v;
      int unsigned            w, total, base, fu, fv, acc, j, k;
      int unsigned            wt [NBR_N];
      int unsigned            offs [NBR_N];
      logic [TEXEL_W-1:0]     px [NBR_N];
      logic [OUT_TDATA_W-1:0] want;
      if (cmd == CMD_WRITE) begin
        texels[beat[IN_ADDR_LSB +: ADDR_IN_W]] = beat[IN_ARGB_LSB +: TEXEL_W];
        return;
      end
      u     = beat[IN_U_LSB +: COORD_W];
      v     = beat[IN_V_LSB +: COORD_W];
      w     = dim_of(width_reg);
      total = w * dim_of(height_reg);
      base  = 32'(v >> FRAC_BITS) * w + 32'(u >> FRAC_BITS);
      offs  = '{0, 1, w, w + 1};
      if (bilinear == FILTER_NEAREST) begin
        // Full weight on the base texel reproduces the plain fetch
        wt = '{WEIGHT_ONE, 0, 0, 0};
      end else begin
        fu = 32'(u[FRAC_BITS-1:0]);
        fv = 32'(v[FRAC_BITS-1:0]);
        wt[0] = ((WEIGHT_ONE - fu) * (WEIGHT_ONE - fv)) >> 8;
        wt[1] = (fu * (WEIGHT_ONE - fv)) >> 8;
        wt[2] = ((WEIGHT_ONE - fu) * fv) >> 8;
        wt[3] = (fu * fv) >> 8;
      end
      for (k = 0; k < NBR_N; k++) px[k] = texels[((base + offs[k]) % total) % TEXEL_DEPTH];
      // Result lanes run alpha first, the texel holds alpha in its top byte
      for (j = 0; j < NUM_CHAN; j++) begin
        acc = 0;
        for (k = 0; k < NBR_N; k++) acc += px[k][CHAN_W*(NUM_CHAN-1-j) +: CHAN_W] * wt[k];
        want[CHAN_W*j +: CHAN_W] = CHAN_W'(acc >> 8);
      end
      pending_samples.push_back(want);
    endfunction

    function void take_result(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      int                     j;
      if (pending_samples.size() == 0) begin
        flag($sformatf("result %h with no sample outstanding", got));
        return;
      end
      want = pending_samples.pop_front();
      for (j = 0; j < NUM_CHAN; j++)
        if (got[CHAN_W*j +: CHAN_W] !== want[CHAN_W*j +: CHAN_W])
          flag($sformatf("%s expected %02h, got %02h", lane_name[j],
                         want[CHAN_W*j +: CHAN_W], got[CHAN_W*j +: CHAN_W]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;   // texel_address, texel_argb, coord_u, coord_v
  logic                   in_tuser  = 1'b0; // command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // out_alpha, out_red, out_green, out_blue
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  sample_checker sb = new();

  bit seeded [TEXEL_DEPTH];   // texels the sender has written at least once

  int burst_left = 0;   // beats left in the current sender burst
  int hold_reqs  = 0;   // bumped by the stimulus to ask for a long hold-off
  int hold_seen  = 0;
  int hold_left  = 0;
  int rx_tick    = 0;

  always #5 clk = ~clk;

  texture_sampler_bilinear DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Monitors: feed every accepted beat and register write to the predictor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        sb.take_config(cfg_paddr, cfg_pwdata);
      if (in_tvalid && in_tready) sb.take_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.take_result(out_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: rotate through stall patterns on the upper tick bits, and hold off
  // for a long stretch whenever the stimulus asks for it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      case (rx_tick[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 1) == 0);
        2'd2:    out_tready <= (rx_tick[1:0] == 2'd0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one beat and hold it until accepted; open a random gap
  // between bursts, but keep tvalid high straight through a burst
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic cmd, input logic [IN_TDATA_W-1:0] beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Coordinates ride along as noise so every tdata bit toggles
  task automatic send_write(input logic [ADDR_IN_W-1:0] addr, input logic [TEXEL_W-1:0] argb);
    logic [COORD_W-1:0] nu, nv;
    nu = COORD_W'($urandom());
    nv = COORD_W'($urandom());
    seeded[addr] = 1'b1;
    push_beat(CMD_WRITE, {nv, nu, argb, addr});
  endtask

  // Write every texel the sample can reach that has never been written, then
  // send the sample itself
  task automatic send_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    logic [ADDR_IN_W-1:0] na;
    int unsigned          w, total, base, idx, k, n_nbr;
    int unsigned          offs [NBR_N];
    w     = sb.dim_of(sb.width_reg);
    total = w * sb.dim_of(sb.height_reg);
    base  = 32'(v >> FRAC_BITS) * w + 32'(u >> FRAC_BITS);
    offs  = '{0, 1, w, w + 1};
    n_nbr = (sb.bilinear == FILTER_BILINEAR) ? NBR_N : 1;
    for (k = 0; k < n_nbr; k++) begin
      idx = ((base + offs[k]) % total) % TEXEL_DEPTH;
      if (!seeded[idx]) send_write(ADDR_IN_W'(idx), $urandom());
    end
    na = ADDR_IN_W'($urandom());
    push_beat(CMD_SAMPLE, {v, u, 32'($urandom()), na});
  endtask

  // Bias coordinates toward the live texture and its edges
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
    logic [COORD_W-1:0] c;
    c = COORD_W'($urandom());
    case ($urandom_range(0, 3))
      0: ;
      1: c[COORD_W-1:FRAC_BITS] = (COORD_W-FRAC_BITS)'($urandom_range(0, dim - 1));
      2: c[COORD_W-1:FRAC_BITS] = (COORD_W-FRAC_BITS)'(dim - 1);
      default: c[FRAC_BITS-1:0] = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
    return c;
  endfunction

  // Drop tvalid and wait until every sample has come back and the pipe is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register access: setup cycle, access cycle, then an idle cycle
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== sb.reg_value(idx))
      sb.flag($sformatf("register %0d read %h, expected %h", idx, cfg_prdata,
                        sb.reg_value(idx)));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    reg_check(REG_FILTER_MODE);
    reg_check(REG_TEX_WIDTH);
    reg_check(REG_TEX_HEIGHT);
  endtask

  // Upper data bits carry noise; only the register's own bits must stick
  task automatic set_filter(input logic mode, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h);
    logic [CFG_DATA_W-1:0] word;
    drain();
    word = $urandom();
    word[0] = mode;
    reg_write(REG_FILTER_MODE, word);
    word = $urandom();
    word[DIM_W-1:0] = w;
    reg_write(REG_TEX_WIDTH, word);
    word = $urandom();
    word[DIM_W-1:0] = h;
    reg_write(REG_TEX_HEIGHT, word);
    check_regs();
  endtask

  // Mostly samples inside and around the texture, with texel rewrites mixed in
  task automatic random_phase(input int n_items);
    int unsigned w, h;
    int          k;
    w = sb.dim_of(sb.width_reg);
    h = sb.dim_of(sb.height_reg);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) < 3) send_write(ADDR_IN_W'($urandom()), $urandom());
      else send_sample(pick_coord(w), pick_coord(h));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, bilinear on 256x256: write extremes, then blend them
    send_write(16'h0000, 32'hFFFF_FFFF);
    send_write(16'hFFFF, 32'h0000_0000);
    send_write(16'h0001, 32'h00FF_00FF);
    send_write(16'h0100, 32'hFF00_FF00);
    send_write(16'h0101, 32'h8080_8080);
    send_sample(20'h00000, 20'h00000);   // zero fractions
    send_sample(20'h000FF, 20'h000FF);   // largest fractions
    send_sample(20'h00080, 20'h00040);
    send_sample(20'hFFFFF, 20'hFFFFF);   // largest integer parts, wrap
    send_sample(20'h0FF80, 20'h0FF80);   // right neighbor wraps to texel 0, lower ones to 255, 256
    send_sample(20'h10000, 20'h00000);   // column past the width lands on next row
    send_sample(20'h0FFFF, 20'h00000);

    // Nearest on 256x256
    set_filter(FILTER_NEAREST, 9'd256, 9'd256);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h0FFFF, 20'h000FF);
    send_sample(20'h00001, 20'h0FF00);
    random_phase(80);

    // Single texel, then zero sizes that must behave as one
    set_filter(FILTER_BILINEAR, 9'd1, 9'd1);
    random_phase(60);
    set_filter(FILTER_NEAREST, 9'd0, 9'd0);
    random_phase(40);

    // Oversized height saturates; the spare register slot must ignore writes
    set_filter(FILTER_BILINEAR, 9'd0, 9'd300);
    reg_write(REG_SPARE, $urandom());
    check_regs();
    random_phase(60);

    // Oversized width; stall the receiver long enough to back up the input
    set_filter(FILTER_BILINEAR, 9'd511, 9'd2);
    hold_reqs <= hold_reqs + 1;
    random_phase(80);

    set_filter(FILTER_NEAREST, 9'd3, 9'd511);
    random_phase(60);
    set_filter(FILTER_BILINEAR, 9'd7, 9'd5);
    random_phase(80);
    set_filter(FILTER_BILINEAR, 9'd256, 9'd1);
    random_phase(60);
    set_filter(FILTER_BILINEAR, 9'd1, 9'd256);
    random_phase(60);
    set_filter(FILTER_NEAREST, 9'd100, 9'd200);
    random_phase(60);

    for (p = 0; p < 4; p++) begin
      set_filter(1'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 511)),
                 DIM_W'($urandom_range(0, 511)));
      random_phase(30);
    end

    // Let every sample come back, then a quiet stretch to catch strays
    drain();
    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
